// ----- sv/spfa_pkg.sv -----
// spfa_pkg: shared types, codes and constants for the sph pressure force block
// used by the particle store, the arithmetic unit, the top level and the checker
// no dependencies
package spfa_pkg;

  localparam int IDX_W  = 10;
  localparam int DATA_W = 64;
  localparam int UREG_W = 63;
  localparam int CFG_IDX_W = 3;
  localparam int MAX_PARTICLES_DEF = 1024;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DENSITY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_OF_SOUND  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EOS_EXPONENT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_HALF_RADIUS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRADIENT_COEFF  = 3'd4;

  localparam logic [UREG_W-1:0] RST_TARGET_DENSITY  = 63'd4294967296000;
  localparam logic [UREG_W-1:0] RST_SPEED_OF_SOUND  = 63'd429496729600;
  localparam logic [2:0]        RST_EOS_EXPONENT    = 3'd7;
  localparam logic [UREG_W-1:0] RST_INV_HALF_RADIUS = 63'd246837200000;
  localparam logic [UREG_W-1:0] RST_GRADIENT_COEFF  = 63'd11186010000000000;

  // Q32.32 constants
  localparam logic signed [DATA_W-1:0] FX_ZERO = 64'sd0;
  localparam logic signed [DATA_W-1:0] FX_ONE  = 64'sh0000_0001_0000_0000;
  localparam logic signed [DATA_W-1:0] FX_TWO  = 64'sh0000_0002_0000_0000;
  localparam logic signed [DATA_W-1:0] FX_FOUR = 64'sh0000_0004_0000_0000;
  localparam logic signed [DATA_W-1:0] FX_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [DATA_W-1:0] FX_MIN  = 64'sh8000_0000_0000_0000;

  // request kinds and result kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_PAIR = 1'b1;
  localparam logic KIND_PRESSURE = 1'b0;
  localparam logic KIND_FORCE    = 1'b1;

  // arithmetic unit operations
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_SQRT = 3'd4;

  typedef struct packed {
    logic [2:0]               op;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
  } alu_req_t;

  // one particle row of the store
  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic [UREG_W-1:0]        mass;
    logic [UREG_W-1:0]        density;
    logic [UREG_W-1:0]        pressure;
  } row_t;

endpackage

// ----- sv/spfa_store.sv -----
// spfa_store: particle row memory, one write port and one read port
// read data registered; uses spfa_pkg
module spfa_store #(
  parameter int DEPTH = spfa_pkg::MAX_PARTICLES_DEF,
  parameter int AW    = $clog2(spfa_pkg::MAX_PARTICLES_DEF)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  spfa_pkg::row_t    wdata,
  input  logic [AW-1:0]     raddr,
  output spfa_pkg::row_t    rdata
);

  spfa_pkg::row_t mem [DEPTH];
  spfa_pkg::row_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/spfa_alu.sv -----
// spfa_alu: shared multi-cycle Q32.32 unit: saturating add/sub, multiply from
// four 32x32 partial products, bit-serial divide and square root; uses spfa_pkg
module spfa_alu (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  spfa_pkg::alu_req_t        req,
  output logic                      done,
  output logic signed [63:0]        result
);

  logic        busy_r;
  logic        done_r;
  logic [2:0]  op_r;
  logic [6:0]  cnt_r;
  logic [63:0] x_r, y_r;
  logic        neg_r;
  logic [63:0] p0_r, p1_r, p2_r, p3_r, r_r;
  logic [95:0] sh_r;
  logic [63:0] rem_r, q_r;
  logic        over_r;
  logic signed [63:0] res_r;

  logic [63:0] amag, bmag;
  logic [31:0] mop_a, mop_b;
  logic [63:0] prod, up, mmag;
  logic        dbit, dge;
  logic [63:0] drem;
  logic [63:0] srem, strial;
  logic        sge;

  function automatic logic signed [63:0] from_mag(input logic neg, input logic [63:0] m);
    logic signed [63:0] r;
    begin
      if (!neg) r = m[63] ? spfa_pkg::FX_MAX : $signed(m);
      else      r = m[63] ? spfa_pkg::FX_MIN : $signed(64'd0 - m);
      return r;
    end
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    begin
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? spfa_pkg::FX_MIN : spfa_pkg::FX_MAX;
      return s;
    end
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    begin
      s = a - b;
      if (a[63] != b[63] && s[63] != a[63]) s = a[63] ? spfa_pkg::FX_MIN : spfa_pkg::FX_MAX;
      return s;
    end
  endfunction

  assign amag = req.a[63] ? 64'd0 - req.a : req.a;
  assign bmag = req.b[63] ? 64'd0 - req.b : req.b;

  // one 32x32 multiplier, partial product chosen by the step count
  assign mop_a = cnt_r[0] ? x_r[63:32] : x_r[31:0];
  assign mop_b = cnt_r[1] ? y_r[63:32] : y_r[31:0];
  assign prod  = {32'd0, mop_a} * {32'd0, mop_b};
  assign up    = p3_r + {32'd0, p1_r[63:32]} + {32'd0, p2_r[63:32]} + {32'd0, r_r[63:32]};
  assign mmag  = (up > 64'h0000_0000_FFFF_FFFF) ? '1 : {up[31:0], r_r[31:0]};

  // restoring divide, one quotient bit a cycle
  assign dbit = sh_r[95];
  assign drem = {rem_r[62:0], dbit};
  assign dge  = rem_r[63] || (drem >= y_r);

  // square root, one root bit a cycle
  assign srem   = {rem_r[61:0], sh_r[95:94]};
  assign strial = {q_r[61:0], 2'b01};
  assign sge    = srem >= strial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          op_r  <= req.op;
          cnt_r <= '0;
          neg_r <= req.a[63] ^ req.b[63];
          case (req.op)
            spfa_pkg::OP_ADD: begin
              res_r  <= sat_add(req.a, req.b);
              done_r <= 1'b1;
            end
            spfa_pkg::OP_SUB: begin
              res_r  <= sat_sub(req.a, req.b);
              done_r <= 1'b1;
            end
            spfa_pkg::OP_MUL: begin
              x_r    <= amag;
              y_r    <= bmag;
              busy_r <= 1'b1;
            end
            spfa_pkg::OP_DIV: begin
              if (bmag == 64'd0) begin
                res_r  <= (amag == 64'd0) ? spfa_pkg::FX_ZERO :
                          (req.a[63] ? spfa_pkg::FX_MIN : spfa_pkg::FX_MAX);
                done_r <= 1'b1;
              end else begin
                sh_r   <= {amag, 32'd0};
                y_r    <= bmag;
                rem_r  <= '0;
                q_r    <= '0;
                over_r <= 1'b0;
                busy_r <= 1'b1;
              end
            end
            spfa_pkg::OP_SQRT: begin
              sh_r   <= {(req.a[63] ? 64'd0 : req.a), 32'd0};
              rem_r  <= '0;
              q_r    <= '0;
              busy_r <= 1'b1;
            end
            default: begin
              res_r  <= spfa_pkg::FX_ZERO;
              done_r <= 1'b1;
            end
          endcase
        end
      end else begin
        case (op_r)
          spfa_pkg::OP_MUL: begin
            cnt_r <= cnt_r + 7'd1;
            case (cnt_r)
              7'd0: p0_r <= prod;
              7'd1: p1_r <= prod;
              7'd2: p2_r <= prod;
              7'd3: p3_r <= prod;
              7'd4: r_r <= {32'd0, p0_r[63:32]} + {32'd0, p1_r[31:0]} + {32'd0, p2_r[31:0]};
              default: begin
                res_r  <= from_mag(neg_r, mmag);
                done_r <= 1'b1;
                busy_r <= 1'b0;
              end
            endcase
          end
          spfa_pkg::OP_DIV: begin
            if (cnt_r < 7'd96) begin
              cnt_r  <= cnt_r + 7'd1;
              sh_r   <= {sh_r[94:0], 1'b0};
              rem_r  <= dge ? drem - y_r : drem;
              over_r <= over_r | q_r[63];
              q_r    <= {q_r[62:0], dge};
            end else begin
              res_r  <= from_mag(neg_r, over_r ? '1 : q_r);
              done_r <= 1'b1;
              busy_r <= 1'b0;
            end
          end
          spfa_pkg::OP_SQRT: begin
            if (cnt_r < 7'd48) begin
              cnt_r <= cnt_r + 7'd1;
              sh_r  <= {sh_r[93:0], 2'b00};
              rem_r <= sge ? srem - strial : srem;
              q_r   <= {q_r[62:0], sge};
            end else begin
              res_r  <= $signed(q_r);
              done_r <= 1'b1;
              busy_r <= 1'b0;
            end
          end
          default: begin
            done_r <= 1'b1;
            busy_r <= 1'b0;
          end
        endcase
      end
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

// ----- sv/sph_pressure_force_accumulator.sv -----
// sph_pressure_force_accumulator: top level, request sequencer, config registers,
// force accumulator and output register; uses spfa_pkg, spfa_store, spfa_alu
//
//  port group | dir | handshake         | carries
//  in_*       | in  | in_valid/in_ready | load or pair request
//  out_*      | out | out_valid/out_ready | pressure or force result
//  cfg_*      | in  | cfg_we            | register index and data
//
// one request at a time; the time for a load grows with g, and a pair within range
// is dominated by its seven divides in the bit-serial divider and the square root;
// a multiply takes longer than an add or subtract. equal positions end a pair early,
// and so does a neighbour out of range.
// an index at or beyond MAX_PARTICLES is brought into range by wrap subtractions.
// synchronous active-low reset sets control and config to their reset values and clears the accumulator.
// a finished result waits in the output register while the next request is taken.
module sph_pressure_force_accumulator #(
  parameter int MAX_PARTICLES = spfa_pkg::MAX_PARTICLES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_req_type,
  input  logic [9:0]          in_index_a,
  input  logic [9:0]          in_index_b,
  input  logic signed [63:0]  in_pos_x,
  input  logic signed [63:0]  in_pos_y,
  input  logic signed [63:0]  in_pos_z,
  input  logic [62:0]         in_mass,
  input  logic [62:0]         in_density,
  input  logic                in_last_neighbour,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_result_kind,
  output logic [9:0]          out_particle_index,
  output logic [62:0]         out_pressure,
  output logic signed [63:0]  out_force_x,
  output logic signed [63:0]  out_force_y,
  output logic signed [63:0]  out_force_z,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [62:0]         cfg_wdata
);

  localparam int AW = $clog2(MAX_PARTICLES);
  localparam int IW = spfa_pkg::IDX_W;
  localparam logic [16:0] MAXV = 17'(MAX_PARTICLES);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_WRAP  = 4'd1;
  localparam logic [3:0] ST_RDA   = 4'd2;
  localparam logic [3:0] ST_RDB   = 4'd3;
  localparam logic [3:0] ST_CAPB  = 4'd4;
  localparam logic [3:0] ST_ISSUE = 4'd5;
  localparam logic [3:0] ST_WAIT  = 4'd6;
  localparam logic [3:0] ST_NEXT  = 4'd7;
  localparam logic [3:0] ST_WRITE = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;

  // operand and destination codes of the step program
  localparam logic [5:0] R_ZERO = 6'd0;
  localparam logic [5:0] R_ONE  = 6'd1;
  localparam logic [5:0] R_TWO  = 6'd2;
  localparam logic [5:0] R_FOUR = 6'd3;
  localparam logic [5:0] R_RHO0 = 6'd4;
  localparam logic [5:0] R_C    = 6'd5;
  localparam logic [5:0] R_IHR  = 6'd6;
  localparam logic [5:0] R_COEF = 6'd7;
  localparam logic [5:0] R_GQ   = 6'd8;
  localparam logic [5:0] R_XA   = 6'd9;
  localparam logic [5:0] R_YA   = 6'd10;
  localparam logic [5:0] R_ZA   = 6'd11;
  localparam logic [5:0] R_MA   = 6'd12;
  localparam logic [5:0] R_RA   = 6'd13;
  localparam logic [5:0] R_PA   = 6'd14;
  localparam logic [5:0] R_XB   = 6'd15;
  localparam logic [5:0] R_YB   = 6'd16;
  localparam logic [5:0] R_ZB   = 6'd17;
  localparam logic [5:0] R_MB   = 6'd18;
  localparam logic [5:0] R_RB   = 6'd19;
  localparam logic [5:0] R_PB   = 6'd20;
  localparam logic [5:0] R_DX   = 6'd21;
  localparam logic [5:0] R_DY   = 6'd22;
  localparam logic [5:0] R_DZ   = 6'd23;
  localparam logic [5:0] R_DIST = 6'd24;
  localparam logic [5:0] R_Q    = 6'd25;
  localparam logic [5:0] R_T    = 6'd26;
  localparam logic [5:0] R_F    = 6'd27;
  localparam logic [5:0] R_T1   = 6'd28;
  localparam logic [5:0] R_T2   = 6'd29;
  localparam logic [5:0] R_AX   = 6'd30;
  localparam logic [5:0] R_AY   = 6'd31;
  localparam logic [5:0] R_AZ   = 6'd32;

  // program steps where control branches
  localparam logic [5:0] S_PAIR_FIRST = 6'd0;
  localparam logic [5:0] S_DZ         = 6'd2;
  localparam logic [5:0] S_Q          = 6'd9;
  localparam logic [5:0] S_INNER      = 6'd10;
  localparam logic [5:0] S_INNER_END  = 6'd16;
  localparam logic [5:0] S_OUTER      = 6'd17;
  localparam logic [5:0] S_COMMON     = 6'd21;
  localparam logic [5:0] S_PAIR_LAST  = 6'd39;
  localparam logic [5:0] S_LOAD_FIRST = 6'd40;
  localparam logic [5:0] S_POW        = 6'd42;
  localparam logic [5:0] S_DIFF       = 6'd46;
  localparam logic [5:0] S_LOAD_LAST  = 6'd47;

  typedef struct packed {
    logic [2:0] op;
    logic [5:0] sa;
    logic [5:0] sb;
    logic [5:0] dst;
  } step_t;

  function automatic step_t step_rom(input logic [5:0] s);
    step_t r;
    begin
      r = '{spfa_pkg::OP_ADD, R_ZERO, R_ZERO, R_T1};
      case (s)
        6'd0:  r = '{spfa_pkg::OP_SUB,  R_XA,   R_XB,   R_DX};
        6'd1:  r = '{spfa_pkg::OP_SUB,  R_YA,   R_YB,   R_DY};
        6'd2:  r = '{spfa_pkg::OP_SUB,  R_ZA,   R_ZB,   R_DZ};
        6'd3:  r = '{spfa_pkg::OP_MUL,  R_DX,   R_DX,   R_T1};
        6'd4:  r = '{spfa_pkg::OP_MUL,  R_DY,   R_DY,   R_T2};
        6'd5:  r = '{spfa_pkg::OP_ADD,  R_T1,   R_T2,   R_T1};
        6'd6:  r = '{spfa_pkg::OP_MUL,  R_DZ,   R_DZ,   R_T2};
        6'd7:  r = '{spfa_pkg::OP_ADD,  R_T1,   R_T2,   R_T1};
        6'd8:  r = '{spfa_pkg::OP_SQRT, R_T1,   R_ZERO, R_DIST};
        6'd9:  r = '{spfa_pkg::OP_MUL,  R_DIST, R_IHR,  R_Q};
        6'd10: r = '{spfa_pkg::OP_SUB,  R_ONE,  R_Q,    R_T1};
        6'd11: r = '{spfa_pkg::OP_MUL,  R_T1,   R_T1,   R_T1};
        6'd12: r = '{spfa_pkg::OP_MUL,  R_FOUR, R_T1,   R_T1};
        6'd13: r = '{spfa_pkg::OP_SUB,  R_TWO,  R_Q,    R_T2};
        6'd14: r = '{spfa_pkg::OP_MUL,  R_T2,   R_T2,   R_T2};
        6'd15: r = '{spfa_pkg::OP_SUB,  R_T1,   R_T2,   R_T1};
        6'd16: r = '{spfa_pkg::OP_MUL,  R_COEF, R_T1,   R_T};
        6'd17: r = '{spfa_pkg::OP_SUB,  R_TWO,  R_Q,    R_T2};
        6'd18: r = '{spfa_pkg::OP_MUL,  R_T2,   R_T2,   R_T2};
        6'd19: r = '{spfa_pkg::OP_MUL,  R_COEF, R_T2,   R_T2};
        6'd20: r = '{spfa_pkg::OP_SUB,  R_ZERO, R_T2,   R_T};
        6'd21: r = '{spfa_pkg::OP_DIV,  R_PA,   R_RA,   R_T1};
        6'd22: r = '{spfa_pkg::OP_DIV,  R_T1,   R_RA,   R_T1};
        6'd23: r = '{spfa_pkg::OP_DIV,  R_PB,   R_RB,   R_T2};
        6'd24: r = '{spfa_pkg::OP_DIV,  R_T2,   R_RB,   R_T2};
        6'd25: r = '{spfa_pkg::OP_ADD,  R_T1,   R_T2,   R_T1};
        6'd26: r = '{spfa_pkg::OP_MUL,  R_MA,   R_MB,   R_F};
        6'd27: r = '{spfa_pkg::OP_MUL,  R_F,    R_T1,   R_F};
        6'd28: r = '{spfa_pkg::OP_DIV,  R_DX,   R_DIST, R_T1};
        6'd29: r = '{spfa_pkg::OP_MUL,  R_T1,   R_T,    R_T1};
        6'd30: r = '{spfa_pkg::OP_MUL,  R_F,    R_T1,   R_T1};
        6'd31: r = '{spfa_pkg::OP_SUB,  R_AX,   R_T1,   R_AX};
        6'd32: r = '{spfa_pkg::OP_DIV,  R_DY,   R_DIST, R_T1};
        6'd33: r = '{spfa_pkg::OP_MUL,  R_T1,   R_T,    R_T1};
        6'd34: r = '{spfa_pkg::OP_MUL,  R_F,    R_T1,   R_T1};
        6'd35: r = '{spfa_pkg::OP_SUB,  R_AY,   R_T1,   R_AY};
        6'd36: r = '{spfa_pkg::OP_DIV,  R_DZ,   R_DIST, R_T1};
        6'd37: r = '{spfa_pkg::OP_MUL,  R_T1,   R_T,    R_T1};
        6'd38: r = '{spfa_pkg::OP_MUL,  R_F,    R_T1,   R_T1};
        6'd39: r = '{spfa_pkg::OP_SUB,  R_AZ,   R_T1,   R_AZ};
        6'd40: r = '{spfa_pkg::OP_DIV,  R_RA,   R_RHO0, R_T1};
        6'd41: r = '{spfa_pkg::OP_ADD,  R_ONE,  R_ZERO, R_T2};
        6'd42: r = '{spfa_pkg::OP_MUL,  R_T2,   R_T1,   R_T2};
        6'd43: r = '{spfa_pkg::OP_MUL,  R_C,    R_C,    R_F};
        6'd44: r = '{spfa_pkg::OP_MUL,  R_F,    R_RHO0, R_F};
        6'd45: r = '{spfa_pkg::OP_DIV,  R_F,    R_GQ,   R_F};
        6'd46: r = '{spfa_pkg::OP_SUB,  R_T2,   R_ONE,  R_T2};
        6'd47: r = '{spfa_pkg::OP_MUL,  R_F,    R_T2,   R_PA};
        default: r = '{spfa_pkg::OP_ADD, R_ZERO, R_ZERO, R_T1};
      endcase
      return r;
    end
  endfunction

  // control
  logic [3:0]  state_r, state_nxt;
  logic [5:0]  step_r, step_nxt;
  logic [2:0]  pow_cnt_r, pow_cnt_nxt;
  logic        kind_r, kind_nxt;
  logic        out_valid_r;

  // config
  logic [62:0] rho0_r, c_r, ihr_r, coef_r;
  logic [2:0]  g_r;

  // request and working registers
  logic               type_r, last_r;
  logic [IW-1:0]      ia_r, ib_r, orig_r;
  logic signed [63:0] xa_r, ya_r, za_r, ma_r, ra_r, pa_r;
  logic signed [63:0] xb_r, yb_r, zb_r, mb_r, rb_r, pb_r;
  logic signed [63:0] dx_r, dy_r, dz_r, dist_r, q_r, t_r, f_r, t1_r, t2_r;
  logic signed [63:0] ax_r, ay_r, az_r;

  // output register payload
  logic               out_kind_r;
  logic [IW-1:0]      out_index_r;
  logic [62:0]        out_pressure_r;
  logic signed [63:0] out_fx_r, out_fy_r, out_fz_r;

  step_t              cur;
  logic signed [63:0] opa, opb;
  spfa_pkg::alu_req_t alu_req;
  logic               alu_start, alu_done;
  logic signed [63:0] alu_res;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  spfa_pkg::row_t     mem_wdata, mem_rdata;
  logic [AW+IW-1:0]   a_wide, b_wide;
  logic               a_over, b_over;
  logic               in_acc, out_free;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign a_over   = {7'd0, ia_r} >= MAXV;
  assign b_over   = {7'd0, ib_r} >= MAXV;
  assign a_wide   = (AW+IW)'(ia_r);
  assign b_wide   = (AW+IW)'(ib_r);

  assign cur = step_rom(step_r);

  function automatic logic signed [63:0] pick(
    input logic [5:0] s, input logic [62:0] rho0, input logic [62:0] c,
    input logic [62:0] ihr, input logic [62:0] coef, input logic [2:0] g,
    input logic signed [63:0] xa, input logic signed [63:0] ya,
    input logic signed [63:0] za, input logic signed [63:0] ma,
    input logic signed [63:0] ra, input logic signed [63:0] pa,
    input logic signed [63:0] xb, input logic signed [63:0] yb,
    input logic signed [63:0] zb, input logic signed [63:0] mb,
    input logic signed [63:0] rb, input logic signed [63:0] pb,
    input logic signed [63:0] dx, input logic signed [63:0] dy,
    input logic signed [63:0] dz, input logic signed [63:0] dlen,
    input logic signed [63:0] q, input logic signed [63:0] t,
    input logic signed [63:0] f, input logic signed [63:0] t1,
    input logic signed [63:0] t2, input logic signed [63:0] ax,
    input logic signed [63:0] ay, input logic signed [63:0] az);
    logic signed [63:0] v;
    begin
      case (s)
        R_ZERO: v = spfa_pkg::FX_ZERO;
        R_ONE:  v = spfa_pkg::FX_ONE;
        R_TWO:  v = spfa_pkg::FX_TWO;
        R_FOUR: v = spfa_pkg::FX_FOUR;
        R_RHO0: v = $signed({1'b0, rho0});
        R_C:    v = $signed({1'b0, c});
        R_IHR:  v = $signed({1'b0, ihr});
        R_COEF: v = $signed({1'b0, coef});
        R_GQ:   v = $signed({29'd0, g, 32'd0});
        R_XA:   v = xa;
        R_YA:   v = ya;
        R_ZA:   v = za;
        R_MA:   v = ma;
        R_RA:   v = ra;
        R_PA:   v = pa;
        R_XB:   v = xb;
        R_YB:   v = yb;
        R_ZB:   v = zb;
        R_MB:   v = mb;
        R_RB:   v = rb;
        R_PB:   v = pb;
        R_DX:   v = dx;
        R_DY:   v = dy;
        R_DZ:   v = dz;
        R_DIST: v = dlen;
        R_Q:    v = q;
        R_T:    v = t;
        R_F:    v = f;
        R_T1:   v = t1;
        R_T2:   v = t2;
        R_AX:   v = ax;
        R_AY:   v = ay;
        R_AZ:   v = az;
        default: v = spfa_pkg::FX_ZERO;
      endcase
      return v;
    end
  endfunction

  assign opa = pick(cur.sa, rho0_r, c_r, ihr_r, coef_r, g_r, xa_r, ya_r, za_r, ma_r, ra_r,
                    pa_r, xb_r, yb_r, zb_r, mb_r, rb_r, pb_r, dx_r, dy_r, dz_r, dist_r,
                    q_r, t_r, f_r, t1_r, t2_r, ax_r, ay_r, az_r);
  assign opb = pick(cur.sb, rho0_r, c_r, ihr_r, coef_r, g_r, xa_r, ya_r, za_r, ma_r, ra_r,
                    pa_r, xb_r, yb_r, zb_r, mb_r, rb_r, pb_r, dx_r, dy_r, dz_r, dist_r,
                    q_r, t_r, f_r, t1_r, t2_r, ax_r, ay_r, az_r);

  assign alu_req   = '{cur.op, opa, opb};
  assign alu_start = (state_r == ST_ISSUE);

  spfa_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (alu_start),
    .req    (alu_req),
    .done   (alu_done),
    .result (alu_res)
  );

  assign mem_we    = (state_r == ST_WRITE);
  assign mem_waddr = a_wide[AW-1:0];
  assign mem_raddr = (state_r == ST_RDA) ? a_wide[AW-1:0] : b_wide[AW-1:0];
  assign mem_wdata = '{xa_r, ya_r, za_r, ma_r[62:0], ra_r[62:0], pa_r[62:0]};

  spfa_store #(.DEPTH(MAX_PARTICLES), .AW(AW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    pow_cnt_nxt = pow_cnt_r;
    kind_nxt    = kind_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_WRAP;
      end
      ST_WRAP: begin
        if (!a_over && !b_over) begin
          if (type_r == spfa_pkg::REQ_LOAD) begin
            pow_cnt_nxt = '0;
            step_nxt    = S_LOAD_FIRST;
            state_nxt   = (g_r == 3'd0) ? ST_WRITE : ST_ISSUE;
          end else begin
            state_nxt = ST_RDA;
          end
        end
      end
      ST_RDA:  state_nxt = ST_RDB;
      ST_RDB:  state_nxt = ST_CAPB;
      ST_CAPB: begin
        step_nxt  = S_PAIR_FIRST;
        state_nxt = ST_ISSUE;
      end
      ST_ISSUE: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (alu_done) state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        state_nxt = ST_ISSUE;
        step_nxt  = step_r + 6'd1;
        kind_nxt  = spfa_pkg::KIND_FORCE;
        case (step_r)
          S_DZ: begin
            if (dx_r == 64'sd0 && dy_r == 64'sd0 && dz_r == 64'sd0)
              state_nxt = last_r ? ST_FIN : ST_IDLE;
          end
          S_Q: begin
            if (dist_r == 64'sd0 || q_r <= 64'sd0 || q_r >= spfa_pkg::FX_TWO)
              state_nxt = last_r ? ST_FIN : ST_IDLE;
            else if (q_r < spfa_pkg::FX_ONE)
              step_nxt = S_INNER;
            else
              step_nxt = S_OUTER;
          end
          S_INNER_END: step_nxt = S_COMMON;
          S_PAIR_LAST: state_nxt = last_r ? ST_FIN : ST_IDLE;
          S_POW: begin
            // repeat the multiply g times
            pow_cnt_nxt = pow_cnt_r + 3'd1;
            if (pow_cnt_r + 3'd1 < g_r) step_nxt = S_POW;
          end
          S_DIFF: begin
            if (t2_r <= 64'sd0) state_nxt = ST_WRITE;
          end
          S_LOAD_LAST: state_nxt = ST_WRITE;
          default: ;
        endcase
      end
      ST_WRITE: begin
        kind_nxt  = spfa_pkg::KIND_PRESSURE;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      pow_cnt_r   <= '0;
      kind_r      <= spfa_pkg::KIND_PRESSURE;
      out_valid_r <= 1'b0;
      rho0_r      <= spfa_pkg::RST_TARGET_DENSITY;
      c_r         <= spfa_pkg::RST_SPEED_OF_SOUND;
      g_r         <= spfa_pkg::RST_EOS_EXPONENT;
      ihr_r       <= spfa_pkg::RST_INV_HALF_RADIUS;
      coef_r      <= spfa_pkg::RST_GRADIENT_COEFF;
      ax_r        <= '0;
      ay_r        <= '0;
      az_r        <= '0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      pow_cnt_r <= pow_cnt_nxt;
      kind_r    <= (state_r == ST_NEXT || state_r == ST_WRITE) ? kind_nxt : kind_r;

      if (cfg_we) begin
        case (cfg_index)
          spfa_pkg::CFG_TARGET_DENSITY:  rho0_r <= cfg_wdata;
          spfa_pkg::CFG_SPEED_OF_SOUND:  c_r    <= cfg_wdata;
          spfa_pkg::CFG_EOS_EXPONENT:    g_r    <= cfg_wdata[2:0];
          spfa_pkg::CFG_INV_HALF_RADIUS: ihr_r  <= cfg_wdata;
          spfa_pkg::CFG_GRADIENT_COEFF:  coef_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (state_r == ST_WAIT && alu_done) begin
        case (cur.dst)
          R_AX: ax_r <= alu_res;
          R_AY: ay_r <= alu_res;
          R_AZ: az_r <= alu_res;
          default: ;
        endcase
      end

      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
        // a force result empties the accumulator
        if (kind_r == spfa_pkg::KIND_FORCE) begin
          ax_r <= '0;
          ay_r <= '0;
          az_r <= '0;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      type_r <= in_req_type;
      last_r <= in_last_neighbour;
      ia_r   <= in_index_a;
      ib_r   <= in_index_b;
      orig_r <= in_index_a;
      xa_r   <= in_pos_x;
      ya_r   <= in_pos_y;
      za_r   <= in_pos_z;
      ma_r   <= $signed({1'b0, in_mass});
      ra_r   <= $signed({1'b0, in_density});
      pa_r   <= '0;
    end

    if (state_r == ST_WRAP) begin
      if (a_over) ia_r <= ia_r - IW'(MAXV);
      if (b_over) ib_r <= ib_r - IW'(MAXV);
    end

    if (state_r == ST_RDB) begin
      xa_r <= mem_rdata.pos_x;
      ya_r <= mem_rdata.pos_y;
      za_r <= mem_rdata.pos_z;
      ma_r <= $signed({1'b0, mem_rdata.mass});
      ra_r <= $signed({1'b0, mem_rdata.density});
      pa_r <= $signed({1'b0, mem_rdata.pressure});
    end

    if (state_r == ST_CAPB) begin
      xb_r <= mem_rdata.pos_x;
      yb_r <= mem_rdata.pos_y;
      zb_r <= mem_rdata.pos_z;
      mb_r <= $signed({1'b0, mem_rdata.mass});
      rb_r <= $signed({1'b0, mem_rdata.density});
      pb_r <= $signed({1'b0, mem_rdata.pressure});
    end

    if (state_r == ST_WAIT && alu_done) begin
      case (cur.dst)
        R_DX:   dx_r   <= alu_res;
        R_DY:   dy_r   <= alu_res;
        R_DZ:   dz_r   <= alu_res;
        R_DIST: dist_r <= alu_res;
        R_Q:    q_r    <= alu_res;
        R_T:    t_r    <= alu_res;
        R_F:    f_r    <= alu_res;
        R_T1:   t1_r   <= alu_res;
        R_T2:   t2_r   <= alu_res;
        R_PA:   pa_r   <= alu_res;
        default: ;
      endcase
    end

    if (state_r == ST_FIN && out_free) begin
      out_kind_r  <= kind_r;
      out_index_r <= orig_r;
      if (kind_r == spfa_pkg::KIND_FORCE) begin
        out_pressure_r <= '0;
        out_fx_r       <= ax_r;
        out_fy_r       <= ay_r;
        out_fz_r       <= az_r;
      end else begin
        out_pressure_r <= pa_r[62:0];
        out_fx_r       <= '0;
        out_fy_r       <= '0;
        out_fz_r       <= '0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_kind_r;
  assign out_particle_index = out_index_r;
  assign out_pressure       = out_pressure_r;
  assign out_force_x        = out_fx_r;
  assign out_force_y        = out_fy_r;
  assign out_force_z        = out_fz_r;

endmodule

// ----- sv/spfa_checker.sv -----
// spfa_checker: port-level assertions for the sph pressure force block
// bound to sph_pressure_force_accumulator; uses spfa_pkg
module spfa_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_result_kind,
  input logic [62:0]        out_pressure,
  input logic signed [63:0] out_force_x,
  input logic signed [63:0] out_force_y,
  input logic signed [63:0] out_force_z
);

  // one request in flight: ready drops after a request is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  a_pressure_no_force: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == spfa_pkg::KIND_PRESSURE |->
      out_force_x == 64'sd0 && out_force_y == 64'sd0 && out_force_z == 64'sd0)
    else $error("pressure result carries force");

  a_force_no_pressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == spfa_pkg::KIND_FORCE |-> out_pressure == 63'd0)
    else $error("force result carries pressure");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind) &&
      $stable(out_pressure) && $stable(out_force_x))
    else $error("result dropped or changed while stalled");

endmodule

bind sph_pressure_force_accumulator spfa_checker u_spfa_checker (.*);

// ----- tb/sv/testbench.sv -----
// testbench: self-checking bench for sph_pressure_force_accumulator, with a Q32.32
// predictor of pressure and pair-force requests; depends on spfa_pkg and the block
module testbench;

  localparam longint CYCLE_LIMIT = 30_000_000;
  localparam int     SETTLE      = 1500;
  localparam longint M63V        = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint ONE_Q       = 64'h1_0000_0000;

  typedef struct {
    bit          kind;
    bit [9:0]    ia;
    bit [9:0]    ib;
    longint      px, py, pz;
    bit [62:0]   mass;
    bit [62:0]   dens;
    bit          last;
  } request_t;

  typedef struct {
    bit          kind;
    bit [9:0]    idx;
    bit [62:0]   pres;
    longint      fx, fy, fz;
  } outcome_t;

  class force_scoreboard;
    longint   pos_x[1024], pos_y[1024], pos_z[1024];
    longint   mass_q[1024], dens_q[1024], pres_q[1024];
    longint   sum_x, sum_y, sum_z;
    longint   rho0, snd, inv_h, coeff;
    int       g_exp;
    outcome_t pending_q[$];
    int       errors;

    function new();
      sum_x = 0; sum_y = 0; sum_z = 0;
      rho0 = longint'(spfa_pkg::RST_TARGET_DENSITY);
      snd = longint'(spfa_pkg::RST_SPEED_OF_SOUND);
      g_exp = int'(spfa_pkg::RST_EOS_EXPONENT);
      inv_h = longint'(spfa_pkg::RST_INV_HALF_RADIUS);
      coeff = longint'(spfa_pkg::RST_GRADIENT_COEFF);
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, bit [62:0] v);
      case (idx)
        spfa_pkg::CFG_TARGET_DENSITY:  rho0 = longint'(v);
        spfa_pkg::CFG_SPEED_OF_SOUND:  snd = longint'(v);
        spfa_pkg::CFG_EOS_EXPONENT:    g_exp = int'(v[2:0]);
        spfa_pkg::CFG_INV_HALF_RADIUS: inv_h = longint'(v);
        spfa_pkg::CFG_GRADIENT_COEFF:  coeff = longint'(v);
        default: ;
      endcase
    endfunction

    function bit [127:0] mag(longint v);
      bit [63:0] u;
      u = v;
      if (v < 0) u = -u;
      return {64'b0, u};
    endfunction

    function longint clamp_mag(bit neg, bit [127:0] m);
      if (!neg)
        return (m > 128'h7FFF_FFFF_FFFF_FFFF) ? spfa_pkg::FX_MAX : longint'(m[63:0]);
      if (m >= 128'h8000_0000_0000_0000) return spfa_pkg::FX_MIN;
      return -longint'(m[63:0]);
    endfunction

    function longint q_add(longint a, longint b);
      logic signed [64:0] s;
      s = $signed({a[63], a}) + $signed({b[63], b});
      if (s > $signed({1'b0, spfa_pkg::FX_MAX})) return spfa_pkg::FX_MAX;
      if (s < $signed({1'b1, spfa_pkg::FX_MIN})) return spfa_pkg::FX_MIN;
      return s[63:0];
    endfunction

    function longint q_sub(longint a, longint b);
      logic signed [64:0] s;
      s = $signed({a[63], a}) - $signed({b[63], b});
      if (s > $signed({1'b0, spfa_pkg::FX_MAX})) return spfa_pkg::FX_MAX;
      if (s < $signed({1'b1, spfa_pkg::FX_MIN})) return spfa_pkg::FX_MIN;
      return s[63:0];
    endfunction

    function longint q_mul(longint a, longint b);
      return clamp_mag((a < 0) != (b < 0), (mag(a) * mag(b)) >> 32);
    endfunction

    function longint q_div(longint a, longint b);
      bit [127:0] n, d;
      n = mag(a);
      d = mag(b);
      if (d == 0) return (n == 0) ? 0 : ((a < 0) ? spfa_pkg::FX_MIN : spfa_pkg::FX_MAX);
      return clamp_mag((a < 0) != (b < 0), (n << 32) / d);
    endfunction

    function longint q_sqrt(longint v);
      bit [127:0] x, root, cand;
      x = (v < 0) ? 0 : (mag(v) << 32);
      root = 0;
      for (int i = 47; i >= 0; i--) begin
        cand = root | (128'd1 << i);
        if (cand * cand <= x) root = cand;
      end
      return longint'(root[63:0]);
    endfunction

    function longint tait_pressure(longint rho);
      longint ratio, pw, scale, diff;
      if (g_exp == 0) return 0;
      ratio = q_div(rho, rho0);
      pw = ONE_Q;
      for (int k = 0; k < g_exp; k++) pw = q_mul(pw, ratio);
      scale = q_mul(q_mul(snd, snd), rho0) / longint'(g_exp);
      diff = q_sub(pw, ONE_Q);
      if (diff <= 0) return 0;
      return q_mul(scale, diff);
    endfunction

    function void add_pair_force(int a, int b);
      longint dx, dy, dz, span, q, t, f, ta, tb, a1, a2;
      dx = q_sub(pos_x[a], pos_x[b]);
      dy = q_sub(pos_y[a], pos_y[b]);
      dz = q_sub(pos_z[a], pos_z[b]);
      if (dx == 0 && dy == 0 && dz == 0) return;
      span = q_sqrt(q_add(q_add(q_mul(dx, dx), q_mul(dy, dy)), q_mul(dz, dz)));
      q = q_mul(span, inv_h);
      if (span == 0 || q <= 0) return;
      a2 = q_sub(spfa_pkg::FX_TWO, q);
      if (q < ONE_Q) begin
        a1 = q_sub(ONE_Q, q);
        t = q_mul(coeff, q_sub(q_mul(spfa_pkg::FX_FOUR, q_mul(a1, a1)), q_mul(a2, a2)));
      end else if (q < spfa_pkg::FX_TWO) begin
        t = q_sub(0, q_mul(coeff, q_mul(a2, a2)));
      end else begin
        return;
      end
      ta = q_div(q_div(pres_q[a], dens_q[a]), dens_q[a]);
      tb = q_div(q_div(pres_q[b], dens_q[b]), dens_q[b]);
      f = q_mul(q_mul(mass_q[a], mass_q[b]), q_add(ta, tb));
      sum_x = q_sub(sum_x, q_mul(f, q_mul(q_div(dx, span), t)));
      sum_y = q_sub(sum_y, q_mul(f, q_mul(q_div(dy, span), t)));
      sum_z = q_sub(sum_z, q_mul(f, q_mul(q_div(dz, span), t)));
    endfunction

    function void note_request(request_t r);
      outcome_t e;
      longint p;
      e.idx = r.ia;
      e.pres = 0; e.fx = 0; e.fy = 0; e.fz = 0;
      if (r.kind == spfa_pkg::REQ_LOAD) begin
        pos_x[r.ia] = r.px; pos_y[r.ia] = r.py; pos_z[r.ia] = r.pz;
        mass_q[r.ia] = longint'(r.mass); dens_q[r.ia] = longint'(r.dens);
        p = tait_pressure(longint'(r.dens));
        pres_q[r.ia] = p;
        e.kind = spfa_pkg::KIND_PRESSURE;
        e.pres = p[62:0];
        pending_q.push_back(e);
      end else begin
        add_pair_force(r.ia, r.ib);
        if (r.last) begin
          e.kind = spfa_pkg::KIND_FORCE;
          e.fx = sum_x; e.fy = sum_y; e.fz = sum_z;
          sum_x = 0; sum_y = 0; sum_z = 0;
          pending_q.push_back(e);
        end
      end
    endfunction

    function void check_result(outcome_t got);
      outcome_t e;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result kind %0d index %0d", got.kind, got.idx);
        return;
      end
      e = pending_q.pop_front();
      if (got.kind != e.kind || got.idx != e.idx || got.pres != e.pres ||
          got.fx != e.fx || got.fy != e.fy || got.fz != e.fz) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp k%0d i%0d p%0h f %0h %0h %0h / got k%0d i%0d p%0h f %0h %0h %0h",
                   e.kind, e.idx, e.pres, e.fx, e.fy, e.fz,
                   got.kind, got.idx, got.pres, got.fx, got.fy, got.fz);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready, in_req_type, in_last_neighbour;
  logic [9:0] in_index_a, in_index_b;
  logic signed [63:0] in_pos_x, in_pos_y, in_pos_z;
  logic [62:0] in_mass, in_density;
  logic out_valid, out_result_kind;
  logic out_ready = 1'b0;
  logic [9:0] out_particle_index;
  logic [62:0] out_pressure;
  logic signed [63:0] out_force_x, out_force_y, out_force_z;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [62:0] cfg_wdata;

  sph_pressure_force_accumulator dut (.*);

  always #4 clk = ~clk;

  force_scoreboard sb;
  int      gap_pct, stall_pct;
  longint  cycles = 0;
  bit      loaded_map[1024];
  int      loaded_q[$];
  longint  base_x, base_y, base_z;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: check, then pick the next stall
  always @(posedge clk) begin
    outcome_t got;
    if (rst_n && out_valid && out_ready && sb != null) begin
      got.kind = out_result_kind; got.idx = out_particle_index; got.pres = out_pressure;
      got.fx = out_force_x; got.fy = out_force_y; got.fz = out_force_z;
      sb.check_result(got);
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic longint rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_request(request_t r);
    int gap;
    gap = ($urandom_range(99) < gap_pct) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= r.kind; in_index_a <= r.ia; in_index_b <= r.ib;
    in_pos_x <= r.px; in_pos_y <= r.py; in_pos_z <= r.pz;
    in_mass <= r.mass; in_density <= r.dens; in_last_neighbour <= r.last;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
    if (r.kind == spfa_pkg::REQ_LOAD && !loaded_map[r.ia]) begin
      loaded_map[r.ia] = 1'b1;
      loaded_q.push_back(r.ia);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, bit [62:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  // idle block: all results in and any silent pair finished
  task automatic configure(longint rho, longint c, bit [2:0] g, longint ih, longint k);
    drain();
    repeat (SETTLE) @(posedge clk);
    write_reg(spfa_pkg::CFG_TARGET_DENSITY, rho[62:0]);
    write_reg(spfa_pkg::CFG_SPEED_OF_SOUND, c[62:0]);
    write_reg(spfa_pkg::CFG_EOS_EXPONENT, {60'd0, g});
    write_reg(spfa_pkg::CFG_INV_HALF_RADIUS, ih[62:0]);
    write_reg(spfa_pkg::CFG_GRADIENT_COEFF, k[62:0]);
    cfg_we <= 1'b0;
  endtask

  function automatic request_t load_req(bit [9:0] ia, longint x, longint y, longint z,
                                        bit [63:0] m, bit [63:0] d);
    request_t r;
    r.kind = spfa_pkg::REQ_LOAD; r.ia = ia; r.ib = 10'($urandom);
    r.px = x; r.py = y; r.pz = z;
    r.mass = m[62:0]; r.dens = d[62:0]; r.last = 1'($urandom);
    return r;
  endfunction

  function automatic request_t pair_req(bit [9:0] ia, bit [9:0] ib, bit last);
    request_t r;
    bit [63:0] v;
    r.kind = spfa_pkg::REQ_PAIR; r.ia = ia; r.ib = ib; r.last = last;
    r.px = rand64(); r.py = rand64(); r.pz = rand64();
    v = rand64();
    r.mass = v[62:0];
    v = rand64();
    r.dens = v[62:0];
    return r;
  endfunction

  // mostly clustered particles near the rest density, some arbitrary noise
  function automatic request_t random_req();
    request_t r;
    bit [9:0] ia;
    bit [63:0] d;
    if (loaded_q.size() < 2 || $urandom_range(99) < 30) begin
      ia = ($urandom_range(99) < 85) ? 10'($urandom_range(0, 31)) : 10'($urandom);
      if ($urandom_range(99) < 85) begin
        d = sb.rho0 - (sb.rho0 >> 5) + (sb.rho0 >> 12) * $urandom_range(0, 511);
        if (d > M63V) d = M63V;
        if (d == 0) d = 1;
        r = load_req(ia, base_x + $signed($urandom_range(0, 1 << 28)) - (1 << 27),
                     base_y + $signed($urandom_range(0, 1 << 28)) - (1 << 27),
                     base_z + $signed($urandom_range(0, 1 << 28)) - (1 << 27),
                     ONE_Q + $urandom_range(0, 32'h7FFF_FFFF), d);
      end else begin
        d = rand64();
        if (d[62:0] == 0) d = 1;
        r = load_req(ia, rand64(), rand64(), rand64(), rand64(), d);
      end
    end else begin
      r = pair_req(10'(loaded_q[$urandom_range(0, loaded_q.size() - 1)]),
                   10'(loaded_q[$urandom_range(0, loaded_q.size() - 1)]),
                   $urandom_range(0, 3) == 0);
    end
    return r;
  endfunction

  task automatic random_phase(int n, int gp, int sp, bit hold_mid);
    gap_pct = gp;
    stall_pct = sp;
    base_x = $signed(rand64()) >>> 24;
    base_y = $signed(rand64()) >>> 24;
    base_z = $signed(rand64()) >>> 24;
    for (int i = 0; i < n; i++) begin
      if (hold_mid && i == n / 2) drain();
      send_request(random_req());
    end
  endtask

  initial begin
    longint d1000;
    d1000 = 64'd1000 * ONE_Q;
    rst_n <= 1'b0;
    in_valid <= 1'b0; in_req_type <= 1'b0; in_index_a <= '0; in_index_b <= '0;
    in_pos_x <= '0; in_pos_y <= '0; in_pos_z <= '0; in_mass <= '0; in_density <= '0;
    in_last_neighbour <= 1'b0;
    cfg_we <= 1'b0; cfg_index <= spfa_pkg::CFG_TARGET_DENSITY; cfg_wdata <= '0;
    gap_pct = 0;
    stall_pct = 0;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: near, mid-range and far neighbours, extremes, clamped pressure
    send_request(load_req(0, 0, 0, 0, ONE_Q, d1000 + 10 * ONE_Q));
    send_request(load_req(1, 43_000_000, 0, 0, ONE_Q, d1000 + 5 * ONE_Q));
    send_request(load_req(2, 0, 107_000_000, -20_000_000, ONE_Q + 12345, d1000 + ONE_Q));
    send_request(load_req(1023, spfa_pkg::FX_MAX, spfa_pkg::FX_MIN, spfa_pkg::FX_MAX,
                          M63V, M63V));
    send_request(load_req(512, spfa_pkg::FX_MIN, spfa_pkg::FX_MAX, 0, 0, 1));
    send_request(load_req(3, 0, 0, 0, 2 * ONE_Q, d1000 - 10 * ONE_Q));
    send_request(load_req(4, -60_000_000, 30_000_000, 10_000_000, ONE_Q, 64'd50000 * ONE_Q));
    send_request(pair_req(0, 1, 1'b0));
    send_request(pair_req(0, 2, 1'b1));
    send_request(pair_req(0, 0, 1'b1));
    send_request(pair_req(0, 3, 1'b1));
    send_request(pair_req(0, 1023, 1'b1));
    send_request(pair_req(1023, 512, 1'b1));
    send_request(pair_req(1, 0, 1'b0));
    send_request(pair_req(2, 1, 1'b0));
    send_request(pair_req(4, 0, 1'b1));
    send_request(pair_req(512, 0, 1'b1));
    send_request(pair_req(0, 4, 1'b0));
    send_request(pair_req(4, 2, 1'b1));

    random_phase(120, 0, 0, 1'b0);
    configure(d1000, 64'd10 * ONE_Q, 3'd7, longint'(spfa_pkg::RST_INV_HALF_RADIUS),
              longint'(spfa_pkg::RST_GRADIENT_COEFF));
    random_phase(250, 66, 0, 1'b1);
    configure(M63V, M63V, 3'd1, 0, M63V);
    random_phase(120, 0, 66, 1'b0);
    configure(0, ONE_Q, 3'd0, M63V, 0);
    random_phase(90, 66, 66, 1'b0);
    configure(ONE_Q, ONE_Q + (ONE_Q >> 1), 3'd3, 64'd40 * ONE_Q, rand64() >> 22);
    random_phase(250, 0, 0, 1'b0);
    configure(d1000, 64'd10 * ONE_Q, 3'd2, longint'(spfa_pkg::RST_INV_HALF_RADIUS),
              longint'(spfa_pkg::RST_GRADIENT_COEFF));
    random_phase(200, 66, 11, 1'b0);

    drain();
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
